FILE: rtl/core/qpsk_pkg.sv
// Package: constants, register map and sine table for the QPSK symbol modulator.
package qpsk_pkg;

  localparam int PHASE_STEPS_DEFAULT = 72;
  localparam int MAX_SPS_DEFAULT     = 64;

  localparam int CFG_W      = 7;
  localparam int SAMPLE_W   = 32;
  localparam int TABLE_IDX_W = 7;
  localparam int QUARTER_N  = 19;

  localparam logic [CFG_W-1:0] SPS_RESET  = 7'd30;
  localparam logic [CFG_W-1:0] STEP_RESET = 7'd4;

  localparam logic REG_SPS  = 1'b0;
  localparam logic REG_STEP = 1'b1;

  localparam logic [1:0] SYM_135 = 2'b00;
  localparam logic [1:0] SYM_45  = 2'b01;
  localparam logic [1:0] SYM_225 = 2'b10;
  localparam logic [1:0] SYM_315 = 2'b11;

  localparam logic [SAMPLE_W-1:0] QUARTER_SINE [QUARTER_N] = '{
    32'd0,          32'd185703301,  32'd369993289,  32'd551467404,  32'd728744519,
    32'd900475448,  32'd1065353216, 32'd1222123002, 32'd1369591694, 32'd1506636966,
    32'd1632215822, 32'd1745372529, 32'd1845245898, 32'd1931075831, 32'd2002209111,
    32'd2058104370, 32'd2098336213, 32'd2122598450, 32'd2130706432
  };

  function automatic logic signed [SAMPLE_W-1:0] sine_sample(
    input logic [TABLE_IDX_W-1:0] idx
  );
    logic [TABLE_IDX_W-1:0] mirror;
    logic [SAMPLE_W-1:0]    mag;
    logic                   neg;
    if (idx <= 7'd18) begin
      mirror = idx;
      neg    = 1'b0;
    end else if (idx <= 7'd36) begin
      mirror = 7'd36 - idx;
      neg    = 1'b0;
    end else if (idx <= 7'd54) begin
      mirror = idx - 7'd36;
      neg    = 1'b1;
    end else begin
      mirror = 7'd72 - idx;
      neg    = 1'b1;
    end
    mag = QUARTER_SINE[mirror[4:0]];
    return neg ? $signed(32'd0 - mag) : $signed(mag);
  endfunction

endpackage

FILE: rtl/core/qpsk_symbol_modulator.sv
// QPSK symbol modulator: register file, sample sequencer and sine pipeline.
// Samples pass from the sequencer through registers s1 and s2 to the output registers.
// Throughput: one sample per cycle unless sample_stall holds it; the single sequencer
//   makes samples_per_symbol samples (1..64) per symbol and takes the next on the last.
// Reset: synchronous, restores samples_per_symbol=30, carrier_step=4, carrier phase 0,
//   and empties the pipeline.
module qpsk_symbol_modulator #(
  parameter int PHASE_STEPS            = qpsk_pkg::PHASE_STEPS_DEFAULT,
  parameter int MAX_SAMPLES_PER_SYMBOL = qpsk_pkg::MAX_SPS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  symbol_valid,
  output logic                                  symbol_stall,
  input  logic [1:0]                            symbol_bits,
  output logic                                  sample_valid,
  input  logic                                  sample_stall,
  output logic signed [qpsk_pkg::SAMPLE_W-1:0]  sample_value,
  output logic                                  last_of_symbol
);

  localparam int PW    = $clog2(PHASE_STEPS);
  localparam int CW    = $clog2(MAX_SAMPLES_PER_SYMBOL + 1);
  localparam int CFG_W = qpsk_pkg::CFG_W;
  localparam int IW    = qpsk_pkg::TABLE_IDX_W;
  localparam int SHIFT = 7 + 2 * PW;
  localparam longint RECIP = ((64'd1 << SHIFT) + PHASE_STEPS - 1) / PHASE_STEPS;
  localparam int KW    = SHIFT - PW + 8;
  localparam logic [KW-1:0] IDX_MULT = KW'(72 * RECIP);
  localparam int PRODW = SHIFT + 8;
  localparam int STEP_TAB_N = 1 << CFG_W;

  localparam logic [PW:0]   PHASE_MAX = (PW+1)'(PHASE_STEPS);
  localparam logic [PW-1:0] OFF_135 = PW'((PHASE_STEPS * 3) / 8);
  localparam logic [PW-1:0] OFF_45  = PW'((PHASE_STEPS * 1) / 8);
  localparam logic [PW-1:0] OFF_225 = PW'((PHASE_STEPS * 5) / 8);
  localparam logic [PW-1:0] OFF_315 = PW'((PHASE_STEPS * 7) / 8);
  localparam logic [CFG_W-1:0] MAX_SPS = CFG_W'(MAX_SAMPLES_PER_SYMBOL);

  localparam logic REG_SPS_C  = qpsk_pkg::REG_SPS;
  localparam logic REG_STEP_C = qpsk_pkg::REG_STEP;

  typedef logic [PW-1:0] step_tab_t [STEP_TAB_N];

  function automatic step_tab_t make_step_tab();
    step_tab_t t;
    for (int i = 0; i < STEP_TAB_N; i++) begin
      t[i] = PW'(i % PHASE_STEPS);
    end
    return t;
  endfunction

  localparam step_tab_t STEP_TAB = make_step_tab();

  logic [CFG_W-1:0] samples_per_symbol;
  logic [CFG_W-1:0] carrier_step;

  logic             busy;
  logic [CW-1:0]    remaining;
  logic [PW-1:0]    sym_off;
  logic [PW-1:0]    phase;

  logic             s1_valid;
  logic             s1_last;
  logic [PW-1:0]    s1_pos;
  logic             s2_valid;
  logic             s2_last;
  logic [IW-1:0]    s2_idx;

  logic             pipe_en;
  logic             last_now;
  logic             issue;
  logic             accept;
  logic             cfg_write;
  logic [CW-1:0]    count_start;
  logic [PW-1:0]    off_next;
  logic [PW-1:0]    step_red;
  logic [PW:0]      pos_sum;
  logic [PW-1:0]    pos;
  logic [PW:0]      phase_sum;
  logic [PW-1:0]    phase_next;
  logic [PRODW-1:0] idx_prod;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_STEP_C) ? {{(32-CFG_W){1'b0}}, carrier_step}
                                              : {{(32-CFG_W){1'b0}}, samples_per_symbol};

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_symbol <= qpsk_pkg::SPS_RESET;
      carrier_step       <= qpsk_pkg::STEP_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SPS_C) begin
        samples_per_symbol <= pwdata[CFG_W-1:0];
      end else begin
        carrier_step <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign pipe_en      = !(sample_valid && sample_stall);
  assign last_now     = (remaining == CW'(1));
  assign issue        = busy && pipe_en;
  assign symbol_stall = busy && !(pipe_en && last_now);
  assign accept       = symbol_valid && !symbol_stall;

  always_comb begin
    if (samples_per_symbol == '0) begin
      count_start = CW'(1);
    end else if (samples_per_symbol > MAX_SPS) begin
      count_start = CW'(MAX_SAMPLES_PER_SYMBOL);
    end else begin
      count_start = samples_per_symbol[CW-1:0];
    end
  end

  always_comb begin
    case (symbol_bits)
      qpsk_pkg::SYM_135: off_next = OFF_135;
      qpsk_pkg::SYM_45:  off_next = OFF_45;
      qpsk_pkg::SYM_225: off_next = OFF_225;
      qpsk_pkg::SYM_315: off_next = OFF_315;
      default:           off_next = OFF_135;
    endcase
  end

  assign step_red   = STEP_TAB[carrier_step];
  assign pos_sum    = {1'b0, phase} + {1'b0, sym_off};
  assign pos        = (pos_sum >= PHASE_MAX) ? PW'(pos_sum - PHASE_MAX)
                                             : pos_sum[PW-1:0];
  assign phase_sum  = {1'b0, phase} + {1'b0, step_red};
  assign phase_next = (phase_sum >= PHASE_MAX) ? PW'(phase_sum - PHASE_MAX)
                                               : phase_sum[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (issue && last_now) begin
        busy <= 1'b0;
      end
      if (issue) begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      remaining <= count_start;
      sym_off   <= off_next;
    end else if (issue) begin
      remaining <= remaining - CW'(1);
    end
  end

  assign idx_prod = PRODW'(s1_pos) * PRODW'(IDX_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      sample_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid     <= busy;
      s2_valid     <= s1_valid;
      sample_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_pos         <= pos;
      s1_last        <= last_now;
      s2_idx         <= idx_prod[SHIFT+IW-1:SHIFT];
      s2_last        <= s1_last;
      sample_value   <= qpsk_pkg::sine_sample(s2_idx);
      last_of_symbol <= s2_last;
    end
  end

endmodule

FILE: test/qpsk_symbol_modulator_test.sv
`timescale 1ns / 1ps
// Testbench for the QPSK symbol modulator: random symbols and settings checked against a predictor.
module qpsk_symbol_modulator_test;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASES        = 72;
  localparam int SPS_MAX       = 64;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SYMBOLS = 33;

  typedef struct packed {
    logic signed [qpsk_pkg::SAMPLE_W-1:0] value;
    logic                                 last;
  } sample_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_e;

  class qpsk_scoreboard;
    int unsigned quarter_wave[qpsk_pkg::QUARTER_N];
    int unsigned sps_reg;
    int unsigned step_reg;
    int unsigned carrier_phase;
    sample_t     expected_samples[$];
    int          errors;

    function new();
      quarter_wave = '{
        0, 185703301, 369993289, 551467404, 728744519,
        900475448, 1065353216, 1222123002, 1369591694, 1506636966,
        1632215822, 1745372529, 1845245898, 1931075831, 2002209111,
        2058104370, 2098336213, 2122598450, 2130706432
      };
      sps_reg       = 32'(qpsk_pkg::SPS_RESET);
      step_reg      = 32'(qpsk_pkg::STEP_RESET);
      carrier_phase = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == qpsk_pkg::REG_SPS) sps_reg = 32'(data[qpsk_pkg::CFG_W-1:0]);
      else if (idx == qpsk_pkg::REG_STEP) step_reg = 32'(data[qpsk_pkg::CFG_W-1:0]);
    endfunction

    function logic signed [qpsk_pkg::SAMPLE_W-1:0] sine_at(int unsigned pos);
      logic [qpsk_pkg::SAMPLE_W-1:0] mag;
      logic                          neg;
      if (pos <= 18) begin
        mag = quarter_wave[pos];
        neg = 1'b0;
      end else if (pos <= 36) begin
        mag = quarter_wave[36 - pos];
        neg = 1'b0;
      end else if (pos <= 54) begin
        mag = quarter_wave[pos - 36];
        neg = 1'b1;
      end else begin
        mag = quarter_wave[72 - pos];
        neg = 1'b1;
      end
      return neg ? $signed(32'd0 - mag) : $signed(mag);
    endfunction

    function int unsigned angle_of(logic [1:0] bits);
      case (bits)
        qpsk_pkg::SYM_135: return PHASES * 3 / 8;
        qpsk_pkg::SYM_45:  return PHASES * 1 / 8;
        qpsk_pkg::SYM_225: return PHASES * 5 / 8;
        default:           return PHASES * 7 / 8;
      endcase
    endfunction

    function void note_symbol(logic [1:0] bits);
      int unsigned count;
      int unsigned angle;
      int unsigned advance;
      sample_t     s;
      count   = sps_reg;
      angle   = angle_of(bits);
      advance = step_reg % PHASES;
      if (count < 1) count = 1;
      if (count > SPS_MAX) count = SPS_MAX;
      for (int unsigned i = 0; i < count; i++) begin
        s.value = sine_at((carrier_phase + angle) % PHASES);
        s.last  = (i + 1 == count);
        expected_samples.push_back(s);
        carrier_phase = (carrier_phase + advance) % PHASES;
      end
    endfunction

    function void check_sample(logic signed [qpsk_pkg::SAMPLE_W-1:0] value, logic last);
      sample_t s;
      if (expected_samples.size() == 0) begin
        $error("unexpected sample: sample_value %0d, last_of_symbol %0b", value, last);
        errors++;
        return;
      end
      s = expected_samples.pop_front();
      if (value !== s.value) begin
        $error("sample_value: expected %0d, got %0d", s.value, value);
        errors++;
      end
      if (last !== s.last) begin
        $error("last_of_symbol: expected %0b, got %0b", s.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [2:0]                           paddr;
  logic [31:0]                          pwdata;
  logic [31:0]                          prdata;
  logic                                 pready;
  logic                                 symbol_valid;
  logic                                 symbol_stall;
  logic [1:0]                           symbol_bits;
  logic                                 sample_valid;
  logic                                 sample_stall;
  logic signed [qpsk_pkg::SAMPLE_W-1:0] sample_value;
  logic                                 last_of_symbol;

  qpsk_scoreboard sb = new();
  stall_mode_e    stall_mode;
  logic           stall_hold;
  int             stall_run;
  int             idle_cycles;

  qpsk_symbol_modulator DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .symbol_valid   (symbol_valid),
    .symbol_stall   (symbol_stall),
    .symbol_bits    (symbol_bits),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample_value   (sample_value),
    .last_of_symbol (last_of_symbol)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (symbol_valid && !symbol_stall) sb.note_symbol(symbol_bits);
      if (sample_valid && !sample_stall) sb.check_sample(sample_value, last_of_symbol);
    end
    if ((symbol_valid && !symbol_stall) || (sample_valid && !sample_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("qpsk_symbol_modulator_test NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (stall_mode)
      STALL_NONE: sample_stall <= 1'b0;
      STALL_RANDOM: sample_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_hold = !stall_hold;
          stall_run  = stall_hold ? $urandom_range(1, 20) : $urandom_range(1, 30);
        end else begin
          stall_run--;
        end
        sample_stall <= stall_hold;
      end
    endcase
  end

  task automatic apb_write(input logic idx, input logic [qpsk_pkg::CFG_W-1:0] val);
    logic [31:0] data;
    data = ($urandom & 32'hFFFF_FF80) | 32'(val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_symbol(input logic [1:0] bits);
    symbol_bits  <= bits;
    symbol_valid <= 1'b1;
    do @(posedge clk); while (symbol_stall);
    @(negedge clk);
  endtask

  task automatic send_symbols(input int n, input int gap_max);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_symbol(2'($urandom));
      left -= burst;
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        symbol_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    symbol_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_all_symbols();
    send_symbol(qpsk_pkg::SYM_135);
    send_symbol(qpsk_pkg::SYM_45);
    send_symbol(qpsk_pkg::SYM_225);
    send_symbol(qpsk_pkg::SYM_315);
    symbol_valid <= 1'b0;
    drain();
  endtask

  initial begin
    int r;
    int sps;
    int gap_max;
    clk          = 1'b0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    symbol_valid = 1'b0;
    symbol_bits  = qpsk_pkg::SYM_135;
    sample_stall = 1'b0;
    stall_mode   = STALL_NONE;
    stall_hold   = 1'b0;
    stall_run    = 0;
    idle_cycles  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_all_symbols();

    stall_mode = STALL_RANDOM;
    apb_write(qpsk_pkg::REG_SPS, 7'd0);
    apb_write(qpsk_pkg::REG_STEP, 7'd71);
    send_all_symbols();

    apb_write(qpsk_pkg::REG_SPS, 7'd127);
    apb_write(qpsk_pkg::REG_STEP, 7'd72);
    send_symbol(qpsk_pkg::SYM_315);
    send_symbol(qpsk_pkg::SYM_135);
    symbol_valid <= 1'b0;
    drain();

    stall_mode = STALL_BURSTY;
    apb_write(qpsk_pkg::REG_SPS, 7'd64);
    apb_write(qpsk_pkg::REG_STEP, 7'd127);
    send_symbol(qpsk_pkg::SYM_225);
    send_symbol(qpsk_pkg::SYM_45);
    symbol_valid <= 1'b0;
    drain();

    apb_write(qpsk_pkg::REG_SPS, 7'd1);
    apb_write(qpsk_pkg::REG_STEP, 7'd0);
    send_all_symbols();

    apb_write(qpsk_pkg::REG_SPS, 7'd2);
    apb_write(qpsk_pkg::REG_STEP, 7'd36);
    send_all_symbols();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      r   = $urandom_range(0, 9);
      sps = (r < 7) ? $urandom_range(1, 8) : $urandom_range(0, 127);
      apb_write(qpsk_pkg::REG_SPS, 7'(sps));
      apb_write(qpsk_pkg::REG_STEP, 7'($urandom_range(0, 127)));
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      send_symbols(PHASE_SYMBOLS, gap_max);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("qpsk_symbol_modulator_test OK");
    end else begin
      $display("qpsk_symbol_modulator_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/qpsk_pkg.sv
rtl/core/qpsk_symbol_modulator.sv
test/qpsk_symbol_modulator_test.sv
